// ===== hdl/acfr_pkg.sv =====
// ----------------------------------------------------------------------------
// acfr_pkg
// Types and constants shared by the addressed command frame receiver.
// ----------------------------------------------------------------------------
package acfr_pkg;

  // frame framing bytes
  localparam logic [7:0] SYNC_BYTE  = 8'hAA;
  localparam logic [7:0] TRAIL_BYTE = 8'h55;

  // command bytes
  localparam logic [7:0] CMD_LEFT  = 8'hF0;
  localparam logic [7:0] CMD_RIGHT = 8'hF1;
  localparam logic [7:0] CMD_STOP  = 8'hF2;
  localparam logic [7:0] CMD_QUERY = 8'hF3;

  // device address after reset
  localparam logic [7:0] ADDR_RESET = 8'd17;

  // motion codes
  localparam logic [1:0] MOTION_STOP    = 2'd0;
  localparam logic [1:0] MOTION_LEFT    = 2'd1;
  localparam logic [1:0] MOTION_RIGHT   = 2'd2;
  localparam logic [1:0] MOTION_INVALID = 2'd3;

  // reply queue
  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  // reply byte index
  localparam logic [2:0] IDX_LAST_ECHO  = 3'd6;
  localparam logic [2:0] IDX_LAST_QUERY = 3'd7;

  // frame parser position
  typedef enum logic [2:0] {
    ST_SYNC0,
    ST_SYNC1,
    ST_ADDR,
    ST_CMD,
    ST_CHECK,
    ST_TRAIL0,
    ST_TRAIL1
  } front_state_e;

  // one received byte with its side information
  typedef struct packed {
    logic [7:0] rx_byte;
    logic       rx_error;
    logic [7:0] status_byte;
    logic [1:0] current_motion;
  } in_item_t;

  // one reply byte
  typedef struct packed {
    logic [7:0] tx_byte;
    logic       last_byte;
    logic [1:0] new_motion;
    logic       stop_request;
  } out_item_t;

  // everything the back end needs to build one reply
  typedef struct packed {
    logic [7:0] address;
    logic [7:0] command;
    logic [7:0] status;
    logic [1:0] new_motion;
    logic       stop_request;
  } reply_desc_t;

endpackage

// ===== hdl/acfr_front.sv =====
// ----------------------------------------------------------------------------
// acfr_front
// Frame parser: checks incoming bytes and pushes a reply descriptor for
// every complete, valid frame.
// ----------------------------------------------------------------------------
module acfr_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [7:0]           cfg_wdata_i,
  input  logic                 take_i,
  input  acfr_pkg::in_item_t   item_i,
  output logic                 push_o,
  output acfr_pkg::reply_desc_t desc_o
);

  acfr_pkg::front_state_e state_q, state_d;
  logic [7:0] dev_addr_q;
  logic [7:0] held_addr_q, held_addr_d;
  logic [7:0] held_cmd_q, held_cmd_d;
  logic [7:0] held_trailer_q, held_trailer_d;
  logic [7:0] rx_b;
  logic [7:0] frame_chk;
  logic [1:0] motion;

  // error bytes count as zero, invalid motion counts as stopped
  assign rx_b      = item_i.rx_error ? 8'h00 : item_i.rx_byte;
  assign motion    = (item_i.current_motion == acfr_pkg::MOTION_INVALID) ?
                     acfr_pkg::MOTION_STOP : item_i.current_motion;
  assign frame_chk = ~(held_addr_q + held_cmd_q);

  // address register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dev_addr_q <= acfr_pkg::ADDR_RESET;
    end else if (cfg_we_i) begin
      dev_addr_q <= cfg_wdata_i;
    end
  end

  // parser state and held bytes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= acfr_pkg::ST_SYNC0;
      held_addr_q    <= '0;
      held_cmd_q     <= '0;
      held_trailer_q <= '0;
    end else begin
      state_q        <= state_d;
      held_addr_q    <= held_addr_d;
      held_cmd_q     <= held_cmd_d;
      held_trailer_q <= held_trailer_d;
    end
  end

  // next state and push
  always_comb begin
    state_d        = state_q;
    held_addr_d    = held_addr_q;
    held_cmd_d     = held_cmd_q;
    held_trailer_d = held_trailer_q;
    push_o         = 1'b0;
    if (take_i) begin
      case (state_q)
        acfr_pkg::ST_SYNC0: begin
          state_d = (rx_b == acfr_pkg::SYNC_BYTE) ? acfr_pkg::ST_SYNC1 : acfr_pkg::ST_SYNC0;
        end
        acfr_pkg::ST_SYNC1: begin
          state_d = (rx_b == acfr_pkg::SYNC_BYTE) ? acfr_pkg::ST_ADDR : acfr_pkg::ST_SYNC0;
        end
        acfr_pkg::ST_ADDR: begin
          held_addr_d = rx_b;
          state_d = (rx_b == dev_addr_q) ? acfr_pkg::ST_CMD : acfr_pkg::ST_SYNC0;
        end
        acfr_pkg::ST_CMD: begin
          held_cmd_d = rx_b;
          state_d = (rx_b inside {[acfr_pkg::CMD_LEFT:acfr_pkg::CMD_QUERY]}) ?
                    acfr_pkg::ST_CHECK : acfr_pkg::ST_SYNC0;
        end
        acfr_pkg::ST_CHECK: begin
          state_d = (rx_b == frame_chk) ? acfr_pkg::ST_TRAIL0 : acfr_pkg::ST_SYNC0;
        end
        acfr_pkg::ST_TRAIL0: begin
          held_trailer_d = rx_b;
          state_d = acfr_pkg::ST_TRAIL1;
        end
        acfr_pkg::ST_TRAIL1: begin
          state_d = acfr_pkg::ST_SYNC0;
          push_o  = (held_trailer_q == acfr_pkg::TRAIL_BYTE) &&
                    (rx_b == acfr_pkg::TRAIL_BYTE);
        end
        default: begin
          state_d = acfr_pkg::ST_SYNC0;
        end
      endcase
    end
  end

  // reply descriptor, sampled with the last frame byte
  always_comb begin
    desc_o.address      = held_addr_q;
    desc_o.command      = held_cmd_q;
    desc_o.status       = item_i.status_byte;
    desc_o.new_motion   = motion;
    desc_o.stop_request = 1'b0;
    case (held_cmd_q)
      acfr_pkg::CMD_LEFT: begin
        desc_o.new_motion   = acfr_pkg::MOTION_LEFT;
        desc_o.stop_request = (motion != acfr_pkg::MOTION_LEFT);
      end
      acfr_pkg::CMD_RIGHT: begin
        desc_o.new_motion   = acfr_pkg::MOTION_RIGHT;
        desc_o.stop_request = (motion != acfr_pkg::MOTION_RIGHT);
      end
      acfr_pkg::CMD_STOP: begin
        desc_o.new_motion = acfr_pkg::MOTION_STOP;
      end
      default: begin
        desc_o.new_motion = motion;
      end
    endcase
  end

endmodule

// ===== hdl/acfr_queue.sv =====
// ----------------------------------------------------------------------------
// acfr_queue
// Short descriptor queue between the frame parser and the reply sender.
// ----------------------------------------------------------------------------
module acfr_queue (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  acfr_pkg::reply_desc_t push_desc_i,
  output logic                  full_o,
  input  logic                  pop_i,
  output logic                  head_valid_o,
  output acfr_pkg::reply_desc_t head_desc_o
);

  acfr_pkg::reply_desc_t entry_q [acfr_pkg::QDEPTH];
  logic [acfr_pkg::QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [acfr_pkg::QCNT_W-1:0] count_q;
  logic do_push, do_pop;

  assign full_o       = (count_q == acfr_pkg::QCNT_W'(acfr_pkg::QDEPTH));
  assign head_valid_o = (count_q != '0);
  assign head_desc_o  = entry_q[rd_ptr_q];
  assign do_push      = push_i && !full_o;
  assign do_pop       = pop_i && head_valid_o;

  // entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= push_desc_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == acfr_pkg::QPTR_W'(acfr_pkg::QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == acfr_pkg::QPTR_W'(acfr_pkg::QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

// ===== hdl/acfr_back.sv =====
// ----------------------------------------------------------------------------
// acfr_back
// Reply sender: walks the head descriptor byte by byte into a registered
// output stage.
// ----------------------------------------------------------------------------
module acfr_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  head_valid_i,
  input  acfr_pkg::reply_desc_t head_desc_i,
  output logic                  pop_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output acfr_pkg::out_item_t   out_data_o
);

  logic [2:0] idx_q;
  logic       out_valid_q;
  acfr_pkg::out_item_t out_q, out_d;
  logic       load;
  logic       is_query;
  logic       is_last;
  logic [7:0] chk_echo;
  logic [7:0] chk_query;

  assign is_query  = (head_desc_i.command == acfr_pkg::CMD_QUERY);
  assign is_last   = (idx_q == (is_query ? acfr_pkg::IDX_LAST_QUERY : acfr_pkg::IDX_LAST_ECHO));
  assign chk_echo  = ~(head_desc_i.address + head_desc_i.command);
  assign chk_query = ~(head_desc_i.address + head_desc_i.command + head_desc_i.status);
  assign load      = head_valid_i && (!out_valid_q || !out_stall_i);
  assign pop_o     = load && is_last;

  // reply byte select
  always_comb begin
    out_d.last_byte    = is_last;
    out_d.new_motion   = head_desc_i.new_motion;
    out_d.stop_request = head_desc_i.stop_request;
    case (idx_q)
      3'd0, 3'd1: out_d.tx_byte = acfr_pkg::SYNC_BYTE;
      3'd2:       out_d.tx_byte = head_desc_i.address;
      3'd3:       out_d.tx_byte = head_desc_i.command;
      3'd4:       out_d.tx_byte = is_query ? head_desc_i.status : chk_echo;
      3'd5:       out_d.tx_byte = is_query ? chk_query : acfr_pkg::TRAIL_BYTE;
      default:    out_d.tx_byte = acfr_pkg::TRAIL_BYTE;
    endcase
  end

  // byte index and output stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (load) begin
        idx_q       <= is_last ? 3'd0 : idx_q + 3'd1;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // output payload
  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== hdl/addressed_command_frame_receiver.sv =====
// Takes one received byte per transfer and returns a full reply frame, one
// byte per output transfer, for every valid seven-byte command frame: seven
// bytes for the motion commands, eight for the status query. A new input
// byte can be taken every cycle; a reply drains at one byte per cycle from
// the sender's output register while out_stall_i is low. A two-entry reply
// queue sits between parser and sender; input is stalled only while that
// queue is full.
// ----------------------------------------------------------------------------
// addressed_command_frame_receiver
// Top level: frame parser, reply queue and reply sender.
// ----------------------------------------------------------------------------
module addressed_command_frame_receiver (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [7:0]          cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  acfr_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output acfr_pkg::out_item_t out_data_o
);

  logic                  take;
  logic                  push;
  logic                  full;
  logic                  pop;
  logic                  head_valid;
  acfr_pkg::reply_desc_t push_desc;
  acfr_pkg::reply_desc_t head_desc;

  // input transfer
  assign in_stall_o = full;
  assign take       = in_valid_i && !full;

  // frame parser
  acfr_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .take_i      (take),
    .item_i      (in_data_i),
    .push_o      (push),
    .desc_o      (push_desc)
  );

  // reply queue
  acfr_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_desc_i  (push_desc),
    .full_o       (full),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_desc_o  (head_desc)
  );

  // reply sender
  acfr_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_desc_i  (head_desc),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_data_o   (out_data_o)
  );

endmodule

// ===== tb/tb_addressed_command_frame_receiver.sv =====
// ----------------------------------------------------------------------------
// tb_addressed_command_frame_receiver
// Self-checking testbench for the addressed command frame receiver. Received
// bytes are fed from a queue through a valid/stall driver. Every accepted
// byte runs through a local frame parser that predicts the reply bytes. The
// monitor checks each reply transfer against the oldest predicted byte. The
// run opens with directed frames, then moves through randomized phases at
// several device addresses and several amounts of sender and receiver idling.
// ----------------------------------------------------------------------------
module tb_addressed_command_frame_receiver;

  localparam int unsigned SETTLE_CYCLES  = 16;
  localparam int unsigned WATCHDOG_LIMIT = 1000;
  localparam int unsigned PRINT_LIMIT    = 100;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                cfg_we_i    = 1'b0;
  logic [7:0]          cfg_wdata_i = 8'h00;
  logic                in_valid_i  = 1'b0;
  logic                in_stall_o;
  acfr_pkg::in_item_t  in_data_i   = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  acfr_pkg::out_item_t out_data_o;

  // bytes waiting to be driven and reply bytes still to arrive
  acfr_pkg::in_item_t  rx_bytes_q[$];
  acfr_pkg::out_item_t reply_bytes_q[$];

  // local copy of the parser state and the address register
  acfr_pkg::front_state_e frame_pos    = acfr_pkg::ST_SYNC0;
  logic [7:0]             device_addr  = acfr_pkg::ADDR_RESET;
  logic [7:0]             held_addr    = 8'h00;
  logic [7:0]             held_cmd     = 8'h00;
  logic [7:0]             held_trailer = 8'h00;

  int unsigned idle_pct     = 0;
  int unsigned stall_pct    = 0;
  bit          stim_on      = 1'b0;
  bit          in_taken     = 1'b0;
  int unsigned err_count    = 0;
  int unsigned replies_seen = 0;
  int unsigned quiet_cycles = 0;

  addressed_command_frame_receiver i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  always #5 clk_i = ~clk_i;

  task automatic flag_error(input string msg);
    if (err_count < PRINT_LIMIT) $display("ERROR: %s", msg);
    err_count++;
  endtask

  // advance the frame parser by one received byte, queue any reply it causes
  task automatic parse_rx_byte(input acfr_pkg::in_item_t item);
    logic [7:0]          b;
    logic [1:0]          motion;
    logic [1:0]          next_motion;
    logic                stop_req;
    logic [7:0]          sum;
    logic [7:0]          reply [8];
    acfr_pkg::out_item_t rb;
    int                  n;
    int                  k;
    b        = item.rx_error ? 8'h00 : item.rx_byte;
    motion   = (item.current_motion == acfr_pkg::MOTION_INVALID) ?
               acfr_pkg::MOTION_STOP : item.current_motion;
    n        = 0;
    stop_req = 1'b0;
    case (frame_pos)
      acfr_pkg::ST_SYNC0: begin
        frame_pos = (b == acfr_pkg::SYNC_BYTE) ? acfr_pkg::ST_SYNC1 : acfr_pkg::ST_SYNC0;
      end
      acfr_pkg::ST_SYNC1: begin
        frame_pos = (b == acfr_pkg::SYNC_BYTE) ? acfr_pkg::ST_ADDR : acfr_pkg::ST_SYNC0;
      end
      acfr_pkg::ST_ADDR: begin
        held_addr = b;
        frame_pos = (b == device_addr) ? acfr_pkg::ST_CMD : acfr_pkg::ST_SYNC0;
      end
      acfr_pkg::ST_CMD: begin
        held_cmd  = b;
        frame_pos = (b >= acfr_pkg::CMD_LEFT && b <= acfr_pkg::CMD_QUERY) ?
                    acfr_pkg::ST_CHECK : acfr_pkg::ST_SYNC0;
      end
      acfr_pkg::ST_CHECK: begin
        sum       = held_addr + held_cmd;
        frame_pos = (b == ~sum) ? acfr_pkg::ST_TRAIL0 : acfr_pkg::ST_SYNC0;
      end
      acfr_pkg::ST_TRAIL0: begin
        held_trailer = b;
        frame_pos    = acfr_pkg::ST_TRAIL1;
      end
      acfr_pkg::ST_TRAIL1: begin
        frame_pos = acfr_pkg::ST_SYNC0;
        if (held_trailer == acfr_pkg::TRAIL_BYTE && b == acfr_pkg::TRAIL_BYTE) n = 7;
      end
      default: frame_pos = acfr_pkg::ST_SYNC0;
    endcase
    if (n == 0) return;

    // completed frame: echo, or status reply for the query
    sum   = held_addr + held_cmd;
    reply = '{acfr_pkg::SYNC_BYTE, acfr_pkg::SYNC_BYTE, held_addr, held_cmd, ~sum,
              acfr_pkg::TRAIL_BYTE, acfr_pkg::TRAIL_BYTE, acfr_pkg::TRAIL_BYTE};
    case (held_cmd)
      acfr_pkg::CMD_LEFT: begin
        stop_req    = (motion != acfr_pkg::MOTION_LEFT);
        next_motion = acfr_pkg::MOTION_LEFT;
      end
      acfr_pkg::CMD_RIGHT: begin
        stop_req    = (motion != acfr_pkg::MOTION_RIGHT);
        next_motion = acfr_pkg::MOTION_RIGHT;
      end
      acfr_pkg::CMD_STOP: next_motion = acfr_pkg::MOTION_STOP;
      default: begin
        next_motion = motion;
        sum         = held_addr + held_cmd + item.status_byte;
        reply[4]    = item.status_byte;
        reply[5]    = ~sum;
        n           = 8;
      end
    endcase
    for (k = 0; k < n; k++) begin
      rb.tx_byte      = reply[k];
      rb.last_byte    = (k == n - 1);
      rb.new_motion   = next_motion;
      rb.stop_request = stop_req;
      reply_bytes_q.push_back(rb);
    end
  endtask

  task automatic queue_byte(input logic [7:0] b, input logic err,
                            input logic [7:0] status, input logic [1:0] motion);
    acfr_pkg::in_item_t item;
    item.rx_byte        = b;
    item.rx_error       = err;
    item.status_byte    = status;
    item.current_motion = motion;
    rx_bytes_q.push_back(item);
  endtask

  // one frame; bad_pos >= 0 spoils that byte, zero bytes may arrive as errors
  task automatic queue_frame(input logic [7:0] addr, input logic [7:0] cmd,
                             input logic [7:0] status, input logic [1:0] motion,
                             input int bad_pos);
    logic [7:0]         fb [7];
    logic [7:0]         sum;
    acfr_pkg::in_item_t item;
    int                 k;
    sum = addr + cmd;
    fb  = '{acfr_pkg::SYNC_BYTE, acfr_pkg::SYNC_BYTE, addr, cmd, ~sum,
            acfr_pkg::TRAIL_BYTE, acfr_pkg::TRAIL_BYTE};
    for (k = 0; k < 7; k++) begin
      item.rx_byte        = fb[k];
      item.rx_error       = 1'b0;
      item.status_byte    = 8'($urandom);
      item.current_motion = 2'($urandom);
      if (k == 6) begin
        item.status_byte    = status;
        item.current_motion = motion;
      end
      if (k == bad_pos) begin
        if ($urandom_range(1) == 1) item.rx_byte = fb[k] ^ 8'($urandom_range(255, 1));
        else item.rx_error = 1'b1;
      end else if (fb[k] == 8'h00 && $urandom_range(2) == 0) begin
        item.rx_byte  = 8'($urandom);
        item.rx_error = 1'b1;
      end
      rx_bytes_q.push_back(item);
    end
  endtask

  // mostly good frames for the current address, some spoiled, some noise
  task automatic queue_random_bytes(input int unsigned n_items);
    int unsigned pick;
    logic [7:0]  cmd;
    while (rx_bytes_q.size() < n_items) begin
      pick = $urandom_range(99);
      cmd  = acfr_pkg::CMD_LEFT + 8'($urandom_range(3));
      if (pick < 70) begin
        queue_frame(device_addr, cmd, 8'($urandom), 2'($urandom), -1);
      end else if (pick < 85) begin
        queue_frame(device_addr, cmd, 8'($urandom), 2'($urandom), $urandom_range(6));
      end else if (pick < 90) begin
        queue_frame(8'($urandom), 8'($urandom), 8'($urandom), 2'($urandom), -1);
      end else begin
        repeat ($urandom_range(4, 1))
          queue_byte(8'($urandom), 1'($urandom), 8'($urandom), 2'($urandom));
      end
    end
  endtask

  // address write while the block is idle
  task automatic write_device_address(input logic [7:0] addr);
    @(negedge clk_i);
    cfg_wdata_i = addr;
    cfg_we_i    = 1'b1;
    device_addr = addr;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    @(posedge clk_i);
  endtask

  // run queued and random bytes until every reply is back, then let it settle
  task automatic run_phase(input int unsigned idle, input int unsigned stall,
                           input int unsigned n_random);
    @(posedge clk_i);
    idle_pct  = idle;
    stall_pct = stall;
    stim_on   = 1'b1;
    queue_random_bytes(n_random);
    while (rx_bytes_q.size() != 0 || in_valid_i || reply_bytes_q.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // driver: new input transfer or idle at the falling edge, random reply stall
  always @(negedge clk_i) begin
    if (stim_on) begin
      out_stall_i <= ($urandom_range(99) < stall_pct);
      if (!in_valid_i || in_taken) begin
        if (rx_bytes_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
          in_data_i  <= rx_bytes_q.pop_front();
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // monitor: predict on input transfers, check reply transfers
  always @(posedge clk_i) begin : monitor
    acfr_pkg::out_item_t want;
    in_taken = in_valid_i && !in_stall_o;
    if (in_taken) parse_rx_byte(in_data_i);
    if (out_valid_o && !out_stall_i) begin
      if (reply_bytes_q.size() == 0) begin
        flag_error($sformatf("reply byte %0d (%h) with none expected",
                             replies_seen, out_data_o.tx_byte));
      end else begin
        want = reply_bytes_q.pop_front();
        if (out_data_o.tx_byte !== want.tx_byte)
          flag_error($sformatf("reply byte %0d: tx_byte %h, expected %h",
                               replies_seen, out_data_o.tx_byte, want.tx_byte));
        if (out_data_o.last_byte !== want.last_byte)
          flag_error($sformatf("reply byte %0d: last_byte %b, expected %b",
                               replies_seen, out_data_o.last_byte, want.last_byte));
        if (out_data_o.new_motion !== want.new_motion)
          flag_error($sformatf("reply byte %0d: new_motion %0d, expected %0d",
                               replies_seen, out_data_o.new_motion, want.new_motion));
        if (out_data_o.stop_request !== want.stop_request)
          flag_error($sformatf("reply byte %0d: stop_request %b, expected %b",
                               replies_seen, out_data_o.stop_request, want.stop_request));
      end
      replies_seen++;
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    logic [7:0] addr_cmd_sum;

    // directed: left with invalid motion, query with invalid motion
    queue_frame(acfr_pkg::ADDR_RESET, acfr_pkg::CMD_LEFT, 8'h00,
                acfr_pkg::MOTION_INVALID, -1);
    queue_frame(acfr_pkg::ADDR_RESET, acfr_pkg::CMD_QUERY, 8'hFF,
                acfr_pkg::MOTION_INVALID, -1);
    // noise, a sync byte with an error, a mismatch that must not restart a frame
    queue_byte(8'hFF, 1'b0, 8'h00, acfr_pkg::MOTION_STOP);
    queue_byte(acfr_pkg::SYNC_BYTE, 1'b0, 8'hFF, acfr_pkg::MOTION_INVALID);
    queue_byte(acfr_pkg::SYNC_BYTE, 1'b1, 8'h00, acfr_pkg::MOTION_STOP);
    queue_byte(acfr_pkg::SYNC_BYTE, 1'b0, 8'h00, acfr_pkg::MOTION_STOP);
    queue_byte(acfr_pkg::SYNC_BYTE, 1'b0, 8'h00, acfr_pkg::MOTION_STOP);
    queue_byte(acfr_pkg::SYNC_BYTE, 1'b0, 8'h00, acfr_pkg::MOTION_STOP);
    // frame head; the address changes before the rest arrives
    queue_byte(acfr_pkg::SYNC_BYTE, 1'b0, 8'h00, acfr_pkg::MOTION_STOP);
    queue_byte(acfr_pkg::SYNC_BYTE, 1'b0, 8'h00, acfr_pkg::MOTION_STOP);
    queue_byte(acfr_pkg::ADDR_RESET, 1'b0, 8'h00, acfr_pkg::MOTION_STOP);

    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    run_phase(0, 0, 0);

    // finish the open frame under the new address
    write_device_address(8'h00);
    addr_cmd_sum = acfr_pkg::ADDR_RESET + acfr_pkg::CMD_RIGHT;
    queue_byte(acfr_pkg::CMD_RIGHT, 1'b0, 8'h00, acfr_pkg::MOTION_STOP);
    queue_byte(~addr_cmd_sum, 1'b0, 8'h00, acfr_pkg::MOTION_STOP);
    queue_byte(acfr_pkg::TRAIL_BYTE, 1'b0, 8'h00, acfr_pkg::MOTION_STOP);
    queue_byte(acfr_pkg::TRAIL_BYTE, 1'b0, 8'hA5, acfr_pkg::MOTION_RIGHT);
    run_phase(0, 0, 52);

    write_device_address(8'hFF);
    run_phase(50, 0, 52);
    // address where a left command gives a zero checksum
    write_device_address(8'h0F);
    run_phase(0, 50, 52);
    write_device_address(8'($urandom));
    run_phase(34, 34, 52);
    write_device_address(8'($urandom));
    run_phase(0, 0, 52);

    if (err_count == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/acfr_pkg.sv
hdl/acfr_front.sv
hdl/acfr_queue.sv
hdl/acfr_back.sv
hdl/addressed_command_frame_receiver.sv
tb/tb_addressed_command_frame_receiver.sv
